@@ hw/rtl/rfp_pkg.sv @@
// Package for the reply frame parser: frame constants, result kinds and
// register indexes. No dependencies.
package rfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hA0;
    localparam logic [7:0] SYNC_SECOND = 8'hA1;
    localparam logic [7:0] TRAIL_CR    = 8'h0D;
    localparam logic [7:0] TRAIL_LF    = 8'h0A;

    localparam logic [7:0] EXPECTED_ID_RESET     = 8'd128;
    localparam logic [7:0] EXPECTED_LENGTH_RESET = 8'd14;

    typedef logic [7:0] byte_t;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_OK      = 2'd1,
        KIND_TIMEOUT = 2'd2
    } kind_t;

    typedef enum logic {
        CFG_EXPECTED_ID     = 1'b0,
        CFG_EXPECTED_LENGTH = 1'b1
    } cfg_index_t;

endpackage

@@ hw/rtl/rfp_if.sv @@
// Valid/ready channels of the reply frame parser: received bytes in,
// parse results out. Depends on rfp_pkg.
interface rfp_rx_if;
    logic          valid;
    logic          ready;
    rfp_pkg::byte_t rx_byte;
    logic          timed_out;

    modport source (output valid, output rx_byte, output timed_out, input ready);
    modport sink   (input valid, input rx_byte, input timed_out, output ready);
endinterface

interface rfp_res_if;
    logic           valid;
    logic           ready;
    rfp_pkg::kind_t kind;
    rfp_pkg::byte_t byte_index;
    rfp_pkg::byte_t byte_value;

    modport source (output valid, output kind, output byte_index, output byte_value,
                    input ready);
    modport sink   (input valid, input kind, input byte_index, input byte_value,
                    output ready);
endinterface

@@ hw/rtl/reply_frame_parser_unit.sv @@
// Reply frame parser: sync hunt, length and id check, payload with index,
// XOR checksum and CR LF trailer. Depends on rfp_pkg and rfp_if.
// Results are registered: a result is valid the cycle after the transfer that causes it.
// Throughput: one byte per cycle while results are taken, set by the single result
// register, which takes a new result in the same cycle as the previous one is transferred.
// Reset: asynchronous, active low; hunt for first sync, registers to defaults.
module reply_frame_parser_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  rfp_pkg::cfg_index_t cfg_index,
    input  rfp_pkg::byte_t      cfg_data,
    rfp_rx_if.sink              rx,
    rfp_res_if.source           res
);
    import rfp_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_LEN_HI  = 4'd2,
        PH_LEN_LO  = 4'd3,
        PH_ID      = 4'd4,
        PH_PAYLOAD = 4'd5,
        PH_CKSUM   = 4'd6,
        PH_CR      = 4'd7,
        PH_LF      = 4'd8
    } phase_t;

    phase_t phase_reg, phase_next;
    byte_t  expected_id_reg, expected_id_next;
    byte_t  expected_length_reg, expected_length_next;
    logic   len_hi_nz_reg, len_hi_nz_next;
    byte_t  len_lo_reg, len_lo_next;
    byte_t  bytes_left_reg, bytes_left_next;
    byte_t  running_xor_reg, running_xor_next;
    byte_t  write_index_reg, write_index_next;
    logic   res_valid_reg, res_valid_next;
    kind_t  kind_reg, kind_next;
    byte_t  byte_index_reg, byte_index_next;
    byte_t  byte_value_reg, byte_value_next;

    logic   rx_take;
    byte_t  b;

    assign rx.ready       = !res_valid_reg || res.ready;
    assign rx_take        = rx.valid && rx.ready;
    assign b              = rx.rx_byte;
    assign res.valid      = res_valid_reg;
    assign res.kind       = kind_reg;
    assign res.byte_index = byte_index_reg;
    assign res.byte_value = byte_value_reg;

    always_comb
    begin
        phase_next           = phase_reg;
        expected_id_next     = expected_id_reg;
        expected_length_next = expected_length_reg;
        len_hi_nz_next       = len_hi_nz_reg;
        len_lo_next          = len_lo_reg;
        bytes_left_next      = bytes_left_reg;
        running_xor_next     = running_xor_reg;
        write_index_next     = write_index_reg;
        res_valid_next       = res_valid_reg && !res.ready;
        kind_next            = kind_reg;
        byte_index_next      = byte_index_reg;
        byte_value_next      = byte_value_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXPECTED_ID:     expected_id_next     = cfg_data;
                CFG_EXPECTED_LENGTH: expected_length_next = cfg_data;
                default:             expected_id_next     = expected_id_reg;
            endcase
        end

        if (rx_take)
        begin
            if (rx.timed_out)
            begin
                phase_next      = PH_HUNT;
                res_valid_next  = 1'b1;
                kind_next       = KIND_TIMEOUT;
                byte_index_next = '0;
                byte_value_next = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_SYNC2:
                        phase_next = (b == SYNC_SECOND) ? PH_LEN_HI : PH_HUNT;
                    PH_LEN_HI:
                    begin
                        len_hi_nz_next = (b != '0);
                        phase_next     = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        len_lo_next = b;
                        phase_next  = PH_ID;
                    end
                    PH_ID:
                    begin
                        if (b != expected_id_reg || len_hi_nz_reg
                            || len_lo_reg != expected_length_reg || len_lo_reg == '0)
                        begin
                            phase_next = PH_HUNT;
                        end
                        else
                        begin
                            running_xor_next = b;
                            write_index_next = 8'd1;
                            bytes_left_next  = len_lo_reg - 8'd1;
                            phase_next       = (len_lo_reg == 8'd1) ? PH_CKSUM : PH_PAYLOAD;
                            res_valid_next   = 1'b1;
                            kind_next        = KIND_BYTE;
                            byte_index_next  = '0;
                            byte_value_next  = b;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        running_xor_next = running_xor_reg ^ b;
                        write_index_next = write_index_reg + 8'd1;
                        bytes_left_next  = bytes_left_reg - 8'd1;
                        if (bytes_left_reg == 8'd1)
                        begin
                            phase_next = PH_CKSUM;
                        end
                        res_valid_next  = 1'b1;
                        kind_next       = KIND_BYTE;
                        byte_index_next = write_index_reg;
                        byte_value_next = b;
                    end
                    PH_CKSUM:
                        phase_next = (b == running_xor_reg) ? PH_CR : PH_HUNT;
                    PH_CR:
                        phase_next = (b == TRAIL_CR) ? PH_LF : PH_HUNT;
                    PH_LF:
                    begin
                        phase_next = PH_HUNT;
                        if (b == TRAIL_LF)
                        begin
                            res_valid_next  = 1'b1;
                            kind_next       = KIND_OK;
                            byte_index_next = '0;
                            byte_value_next = '0;
                        end
                    end
                    default:
                        phase_next = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HUNT;
            expected_id_reg     <= EXPECTED_ID_RESET;
            expected_length_reg <= EXPECTED_LENGTH_RESET;
            len_hi_nz_reg       <= 1'b0;
            len_lo_reg          <= '0;
            bytes_left_reg      <= '0;
            running_xor_reg     <= '0;
            write_index_reg     <= '0;
            res_valid_reg       <= 1'b0;
            kind_reg            <= KIND_BYTE;
            byte_index_reg      <= '0;
            byte_value_reg      <= '0;
        end
        else
        begin
            phase_reg           <= phase_next;
            expected_id_reg     <= expected_id_next;
            expected_length_reg <= expected_length_next;
            len_hi_nz_reg       <= len_hi_nz_next;
            len_lo_reg          <= len_lo_next;
            bytes_left_reg      <= bytes_left_next;
            running_xor_reg     <= running_xor_next;
            write_index_reg     <= write_index_next;
            res_valid_reg       <= res_valid_next;
            kind_reg            <= kind_next;
            byte_index_reg      <= byte_index_next;
            byte_value_reg      <= byte_value_next;
        end
    end

    a_timeout_reported: assert property (@(posedge clk) disable iff (!rst_n)
        rx_take && rx.timed_out |=> res.valid && res.kind == KIND_TIMEOUT)
        else $error("timeout transfer not reported");

    a_payload_emitted: assert property (@(posedge clk) disable iff (!rst_n)
        rx_take && !rx.timed_out && phase_reg == PH_PAYLOAD
        |=> res.valid && res.kind == KIND_BYTE)
        else $error("payload byte not emitted");

    a_non_byte_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind != KIND_BYTE |-> res.byte_index == '0 && res.byte_value == '0)
        else $error("non-byte result carries index or value");

endmodule

@@ dv/tb_reply_frame_parser_unit.sv @@
`timescale 1ns / 100ps
// Testbench for reply_frame_parser_unit: directed frames, then random frame traffic
// over several register settings, checked against an in-bench parse predictor or typed expected rows.
// Depends on rfp_pkg, rfp_if and the parser RTL.
module tb_reply_frame_parser_unit;
    import rfp_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;

    typedef enum logic [3:0] {
        ST_HUNT, ST_SYNC2, ST_LEN_HI, ST_LEN_LO, ST_ID,
        ST_PAYLOAD, ST_CKSUM, ST_CR, ST_LF
    } parse_phase_t;

    typedef struct packed {
        kind_t kind;
        byte_t idx;
        byte_t value;
    } parse_result_t;

    typedef enum logic [1:0] {ROW_MODEL, ROW_TYPED, ROW_CFG} row_op_t;

    // for ROW_CFG rows, b carries the id and val the length
    typedef struct {
        row_op_t op;
        byte_t   b;
        logic    tmo;
        kind_t   kind;
        byte_t   idx;
        byte_t   val;
    } stim_row_t;

    typedef enum int {
        F_NONE, F_SYNC1, F_SYNC2, F_LEN_HI, F_LEN_LO, F_ID, F_CKSUM, F_CR, F_LF, F_TIMEOUT
    } frame_fault_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_index_t cfg_index;
    byte_t cfg_data;

    rfp_rx_if  rx_ch ();
    rfp_res_if res_ch ();

    reply_frame_parser_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_ch),
        .res       (res_ch)
    );

    parse_result_t pending_results[$];
    int unsigned   fail_count = 0;
    int unsigned   sent = 0;
    int unsigned   stall_cycles = 0;
    int unsigned   src_idle_pct = 0;
    int unsigned   snk_idle_pct = 0;
    bit            hold_req = 1'b0;
    bit            typed_flag;
    parse_result_t typed_res;
    byte_t         cur_id = EXPECTED_ID_RESET;
    byte_t         cur_len = EXPECTED_LENGTH_RESET;

    byte_t         model_id = EXPECTED_ID_RESET;
    byte_t         model_len = EXPECTED_LENGTH_RESET;
    parse_phase_t  p_phase = ST_HUNT;
    logic [15:0]   p_length = '0;
    byte_t         p_left = '0;
    byte_t         p_xor = '0;
    byte_t         p_index = '0;

    stim_row_t dir_rows [0:31];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit parse_rx_byte(input byte_t b, input logic tmo,
                                         output parse_result_t r);
        r.kind  = KIND_BYTE;
        r.idx   = '0;
        r.value = '0;
        if (tmo)
        begin
            p_phase = ST_HUNT;
            r.kind  = KIND_TIMEOUT;
            return 1'b1;
        end
        case (p_phase)
            ST_SYNC2:  p_phase = (b == SYNC_SECOND) ? ST_LEN_HI : ST_HUNT;
            ST_LEN_HI:
            begin
                p_length = {b, 8'h00};
                p_phase  = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                p_length[7:0] = b;
                p_phase       = ST_ID;
            end
            ST_ID:
            begin
                if (b != model_id || p_length != {8'h00, model_len} || p_length == 16'd0)
                begin
                    p_phase = ST_HUNT;
                    return 1'b0;
                end
                p_xor   = b;
                p_index = 8'd1;
                p_left  = p_length[7:0] - 8'd1;
                p_phase = (p_left == 8'd0) ? ST_CKSUM : ST_PAYLOAD;
                r.value = b;
                return 1'b1;
            end
            ST_PAYLOAD:
            begin
                r.idx   = p_index;
                r.value = b;
                p_xor   = p_xor ^ b;
                p_index = p_index + 8'd1;
                p_left  = p_left - 8'd1;
                if (p_left == 8'd0)
                    p_phase = ST_CKSUM;
                return 1'b1;
            end
            ST_CKSUM:  p_phase = (b == p_xor) ? ST_CR : ST_HUNT;
            ST_CR:     p_phase = (b == TRAIL_CR) ? ST_LF : ST_HUNT;
            ST_LF:
            begin
                p_phase = ST_HUNT;
                if (b == TRAIL_LF)
                begin
                    r.kind = KIND_OK;
                    return 1'b1;
                end
            end
            default:   p_phase = (b == SYNC_FIRST) ? ST_SYNC2 : ST_HUNT;
        endcase
        return 1'b0;
    endfunction

    task automatic report(input string what, input parse_result_t want,
                          input parse_result_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected kind=%0d idx=%0d val=%02h, got kind=%0d idx=%0d val=%02h",
                     $realtime, what, want.kind, want.idx, want.value,
                     got.kind, got.idx, got.value);
    endtask

    always @(posedge clk)
    begin
        parse_result_t want;
        parse_result_t got;
        bit hit;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_EXPECTED_ID)
                    model_id = cfg_data;
                else
                    model_len = cfg_data;
            end
            if (rx_ch.valid && rx_ch.ready)
            begin
                hit = parse_rx_byte(rx_ch.rx_byte, rx_ch.timed_out, want);
                if (typed_flag)
                    pending_results.push_back(typed_res);
                else if (hit)
                    pending_results.push_back(want);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got.kind  = res_ch.kind;
                got.idx   = res_ch.byte_index;
                got.value = res_ch.byte_value;
                if (pending_results.size() == 0)
                    report("unexpected result", '0, got);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.kind != want.kind || got.idx != want.idx || got.value != want.value)
                        report("result mismatch", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("tb_reply_frame_parser_unit failed");
            $finish;
        end
    end

    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic send_item(input byte_t b, input logic tmo, input bit typed,
                             input parse_result_t tr);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        rx_ch.valid     <= 1'b1;
        rx_ch.rx_byte   <= b;
        rx_ch.timed_out <= tmo;
        typed_flag      <= typed;
        typed_res       <= tr;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic quiesce;
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_config(input byte_t id, input byte_t len);
        cur_id  = id;
        cur_len = len;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_EXPECTED_ID;
        cfg_data  <= id;
        @(posedge clk);
        cfg_index <= CFG_EXPECTED_LENGTH;
        cfg_data  <= len;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_chunk(input bit clean);
        byte_t        fb[$];
        byte_t        chk;
        byte_t        v;
        int           tmo_pos;
        int           n;
        frame_fault_t fault;
        tmo_pos = -1;
        if (!clean && $urandom_range(99) < 20)
        begin
            n = int'($urandom_range(6, 1));
            for (int i = 0; i < n; i++)
            begin
                v = ($urandom_range(3) == 0) ? SYNC_FIRST : byte_t'($urandom);
                send_item(v, ($urandom_range(9) == 0), 1'b0, '0);
            end
            return;
        end
        fb.push_back(SYNC_FIRST);
        fb.push_back(SYNC_SECOND);
        fb.push_back(8'h00);
        fb.push_back(cur_len);
        fb.push_back(cur_id);
        chk = cur_id;
        for (int i = 1; i < int'(cur_len); i++)
        begin
            v = byte_t'($urandom);
            chk ^= v;
            fb.push_back(v);
        end
        fb.push_back(chk);
        fb.push_back(TRAIL_CR);
        fb.push_back(TRAIL_LF);
        n = fb.size();
        fault = F_NONE;
        if (!clean && $urandom_range(99) < 50)
            fault = frame_fault_t'($urandom_range(F_TIMEOUT, F_SYNC1));
        v = byte_t'($urandom_range(255, 1));
        case (fault)
            F_SYNC1:   fb[0] ^= v;
            F_SYNC2:   fb[1] ^= v;
            F_LEN_HI:  fb[2] = v;
            F_LEN_LO:  fb[3] ^= v;
            F_ID:      fb[4] ^= v;
            F_CKSUM:   fb[n - 3] ^= v;
            F_CR:      fb[n - 2] ^= v;
            F_LF:      fb[n - 1] ^= v;
            F_TIMEOUT: tmo_pos = int'($urandom_range(n - 1));
            default:   ;
        endcase
        for (int i = 0; i < n; i++)
            send_item(fb[i], (i == tmo_pos), 1'b0, '0);
    endtask

    initial
    begin : stimulus
        parse_result_t tr;
        byte_t         id;
        byte_t         len;
        int unsigned   budget;
        int unsigned   start;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_EXPECTED_ID;
        cfg_data        <= '0;
        rx_ch.valid     <= 1'b0;
        rx_ch.rx_byte   <= '0;
        rx_ch.timed_out <= 1'b0;
        typed_flag      <= 1'b0;
        typed_res       <= '0;

        dir_rows = '{
            '{ROW_TYPED, 8'h5A,       1'b1, KIND_TIMEOUT, 8'd0, 8'h00},
            '{ROW_MODEL, SYNC_FIRST,  1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_MODEL, SYNC_SECOND, 1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_MODEL, 8'h00,       1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_MODEL, 8'h0E,       1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_TYPED, 8'h80,       1'b0, KIND_BYTE,    8'd0, 8'h80},
            '{ROW_TYPED, 8'hC3,       1'b1, KIND_TIMEOUT, 8'd0, 8'h00},
            '{ROW_CFG,   8'hFF,       1'b0, KIND_BYTE,    8'd0, 8'd2},
            '{ROW_MODEL, SYNC_FIRST,  1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_MODEL, SYNC_SECOND, 1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_MODEL, 8'h00,       1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_MODEL, 8'h02,       1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_TYPED, 8'hFF,       1'b0, KIND_BYTE,    8'd0, 8'hFF},
            '{ROW_TYPED, 8'h00,       1'b0, KIND_BYTE,    8'd1, 8'h00},
            '{ROW_MODEL, 8'hFF,       1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_MODEL, TRAIL_CR,    1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_TYPED, TRAIL_LF,    1'b0, KIND_OK,      8'd0, 8'h00},
            '{ROW_MODEL, SYNC_FIRST,  1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_MODEL, SYNC_SECOND, 1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_MODEL, 8'h01,       1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_MODEL, 8'h02,       1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_MODEL, 8'hFF,       1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_CFG,   8'h00,       1'b0, KIND_BYTE,    8'd0, 8'd1},
            '{ROW_MODEL, SYNC_FIRST,  1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_MODEL, SYNC_SECOND, 1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_MODEL, 8'h00,       1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_MODEL, 8'h01,       1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_TYPED, 8'h00,       1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_MODEL, 8'h00,       1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_MODEL, TRAIL_CR,    1'b0, KIND_BYTE,    8'd0, 8'h00},
            '{ROW_TYPED, TRAIL_LF,    1'b0, KIND_OK,      8'd0, 8'h00},
            '{ROW_MODEL, 8'h3C,       1'b0, KIND_BYTE,    8'd0, 8'h00}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 32;
        snk_idle_pct = 52;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].op == ROW_CFG)
            begin
                quiesce();
                set_config(dir_rows[i].b, dir_rows[i].val);
            end
            else
            begin
                tr.kind  = dir_rows[i].kind;
                tr.idx   = dir_rows[i].idx;
                tr.value = dir_rows[i].val;
                send_item(dir_rows[i].b, dir_rows[i].tmo, (dir_rows[i].op == ROW_TYPED), tr);
            end
        end
        quiesce();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    id = byte_t'($urandom);
                    len = 8'd4;
                    budget = 90;
                end
                1:
                begin
                    id = 8'h00;
                    len = 8'd1;
                    budget = 70;
                end
                2:
                begin
                    id = 8'hFF;
                    len = 8'd255;
                    budget = 1;
                end
                3:
                begin
                    id = byte_t'($urandom);
                    len = 8'd0;
                    budget = 40;
                end
                default:
                begin
                    id = byte_t'($urandom);
                    len = byte_t'($urandom_range(12, 1));
                    budget = 80;
                end
            endcase
            src_idle_pct = (p < 2) ? 32 : (p < 4) ? 52 : 0;
            snk_idle_pct = (p < 2) ? 52 : (p < 4) ? 32 : 0;
            set_config(id, len);
            // hold the result side off while the long frame streams in
            if (p == 2)
                hold_req = 1'b1;
            start = sent;
            while (sent - start < budget)
                send_chunk(p == 2);
            quiesce();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("tb_reply_frame_parser_unit passed");
        else
            $display("tb_reply_frame_parser_unit failed");
        $finish;
    end
endmodule
